### src/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types, constants and the divider step for the strided tensor
// address generator.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int IDX_W      = 32;
  localparam int EXT_W      = 16;
  localparam int STR_W      = 32;
  localparam int PROD_W     = EXT_W + STR_W;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int DIMS       = 3;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = IDX_W / DIV_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_RANK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_0 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_1 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_2 = 3'd7;

  // Partial remainder and the shifting dividend/quotient word.
  typedef struct packed {
    logic [EXT_W-1:0] rem;
    logic [IDX_W-1:0] work;
  } div_word_t;

  // Four (DIV_BITS) restoring division steps; quotient bits enter at the bottom of work.
  function automatic div_word_t div_step(input div_word_t w_in,
                                         input logic [EXT_W-1:0] ext);
    div_word_t      w;
    logic [EXT_W:0] r;
    w = w_in;
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {w.rem, w.work[IDX_W-1]};
      w.work = {w.work[IDX_W-2:0], 1'b0};
      if (r >= {1'b0, ext}) begin
        r = r - {1'b0, ext};
        w.work[0] = 1'b1;
      end
      w.rem = r[EXT_W-1:0];
    end
    return w;
  endfunction

endpackage

### src/sta_div.sv
// ----------------------------------------------------------------------------
// sta_div
// Pipelined restoring divider: index by extent, four quotient bits per
// stage, with the running address carried alongside.
// ----------------------------------------------------------------------------
module sta_div #(
  parameter int AW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_vld,
  input  logic [sta_pkg::IDX_W-1:0] in_idx,
  input  logic [AW-1:0]             in_addr,
  input  logic [sta_pkg::EXT_W-1:0] ext,
  output logic                      out_vld,
  output logic [sta_pkg::IDX_W-1:0] out_quot,
  output logic [sta_pkg::EXT_W-1:0] out_rem,
  output logic [AW-1:0]             out_addr
);
  import sta_pkg::*;

  logic      vld_r  [DIV_STAGES];
  div_word_t word_r [DIV_STAGES];
  logic [AW-1:0] addr_r [DIV_STAGES];

  genvar s;
  generate
    for (s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic          vld_nxt;
      div_word_t     word_in;
      div_word_t     word_nxt;
      logic [AW-1:0] addr_nxt;

      if (s == 0) begin : g_first
        assign vld_nxt  = in_vld;
        assign word_in  = '{rem: '0, work: in_idx};
        assign addr_nxt = in_addr;
      end else begin : g_next
        assign vld_nxt  = vld_r[s-1];
        assign word_in  = word_r[s-1];
        assign addr_nxt = addr_r[s-1];
      end

      assign word_nxt = div_step(word_in, ext);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else if (adv) begin
          vld_r[s] <= vld_nxt;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          word_r[s] <= word_nxt;
          addr_r[s] <= addr_nxt;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_quot = word_r[DIV_STAGES-1].work;
  assign out_rem  = word_r[DIV_STAGES-1].rem;
  assign out_addr = addr_r[DIV_STAGES-1];

endmodule

### src/sta_slot.sv
// ----------------------------------------------------------------------------
// sta_slot
// One dimension: divide the index by the extent, multiply the remainder by
// the stride, then add the product to the running address.
// ----------------------------------------------------------------------------
module sta_slot #(
  parameter int AW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_vld,
  input  logic [sta_pkg::IDX_W-1:0] in_idx,
  input  logic [AW-1:0]             in_addr,
  input  logic [sta_pkg::EXT_W-1:0] ext,
  input  logic [sta_pkg::STR_W-1:0] stride,
  output logic                      out_vld,
  output logic [sta_pkg::IDX_W-1:0] out_idx,
  output logic [AW-1:0]             out_addr
);
  import sta_pkg::*;

  logic              div_vld;
  logic [IDX_W-1:0]  div_quot;
  logic [EXT_W-1:0]  div_rem;
  logic [AW-1:0]     div_addr;

  logic              mul_vld_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [IDX_W-1:0]  mul_idx_r;
  logic [AW-1:0]     mul_addr_r;

  logic              add_vld_r;
  logic [IDX_W-1:0]  add_idx_r;
  logic [AW-1:0]     add_addr_r;
  logic [AW-1:0]     add_addr_nxt;
  logic [PROD_W+63:0] prod_wide;

  sta_div #(.AW(AW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_vld),
    .in_idx   (in_idx),
    .in_addr  (in_addr),
    .ext      (ext),
    .out_vld  (div_vld),
    .out_quot (div_quot),
    .out_rem  (div_rem),
    .out_addr (div_addr)
  );

  assign prod_nxt     = {{STR_W{1'b0}}, div_rem} * {{EXT_W{1'b0}}, stride};
  assign prod_wide    = {64'd0, prod_r};
  assign add_addr_nxt = mul_addr_r + prod_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      add_vld_r <= 1'b0;
    end else if (adv) begin
      mul_vld_r <= div_vld;
      add_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r     <= prod_nxt;
      mul_idx_r  <= div_quot;
      mul_addr_r <= div_addr;
      add_idx_r  <= mul_idx_r;
      add_addr_r <= add_addr_nxt;
    end
  end

  assign out_vld  = add_vld_r;
  assign out_idx  = add_idx_r;
  assign out_addr = add_addr_r;

endmodule

### src/strided_tensor_address_generator.sv
// ----------------------------------------------------------------------------
// strided_tensor_address_generator
// Maps a linear element index to its storage address in a strided view.
// ----------------------------------------------------------------------------
// An index passes the input register, then each slot's divider, multiply and add
// registers, to out_valid. Throughput: one transaction per cycle; each dimension
// is a pipelined restoring divider (4 quotient bits per stage) followed by a
// multiply and an add stage. A stalled output holds the whole pipeline.
// Reset clears all valid bits and loads rank 0, base 0, extents 1, strides 1.
module strided_tensor_address_generator #(
  parameter int MAX_RANK   = 3,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sta_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sta_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sta_pkg::IDX_W-1:0]     in_linear_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ADDR_WIDTH-1:0]         out_element_address
);
  import sta_pkg::*;

  logic [1:0]       rank_r;
  logic [CFG_W-1:0] base_r;
  logic [EXT_W-1:0] ext_r    [DIMS];
  logic [STR_W-1:0] stride_r [DIMS];
  logic [1:0]       rank_eff;
  logic             adv;

  logic                  vld0_r;
  logic [IDX_W-1:0]      idx0_r;
  logic [ADDR_WIDTH-1:0] addr0_r;
  logic [CFG_W+63:0]     base_wide;

  logic                  slot_vld  [MAX_RANK+1];
  logic [IDX_W-1:0]      slot_idx  [MAX_RANK+1];
  logic [ADDR_WIDTH-1:0] slot_addr [MAX_RANK+1];
  logic [EXT_W-1:0]      slot_ext  [MAX_RANK];
  logic [STR_W-1:0]      slot_str  [MAX_RANK];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= 2'd0;
      base_r <= '0;
      for (int d = 0; d < DIMS; d++) begin
        ext_r[d]    <= 16'd1;
        stride_r[d] <= 32'd1;
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RANK:     rank_r      <= cfg_wdata[1:0];
        REG_BASE:     base_r      <= cfg_wdata;
        REG_EXTENT_0: ext_r[0]    <= cfg_wdata[EXT_W-1:0];
        REG_EXTENT_1: ext_r[1]    <= cfg_wdata[EXT_W-1:0];
        REG_EXTENT_2: ext_r[2]    <= cfg_wdata[EXT_W-1:0];
        REG_STRIDE_0: stride_r[0] <= cfg_wdata;
        REG_STRIDE_1: stride_r[1] <= cfg_wdata;
        REG_STRIDE_2: stride_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rank_eff = (rank_r > 2'(MAX_RANK)) ? 2'(MAX_RANK) : rank_r;

  // Slot k handles dimension rank-1-k; unused slots and zero extents divide
  // by one, so the digit is zero and the index passes through.
  always_comb begin
    for (int k = 0; k < MAX_RANK; k++) begin
      logic [1:0]       dim;
      logic [EXT_W-1:0] ext_sel;
      dim = rank_eff - 2'd1 - 2'(k);
      case (dim)
        2'd0: begin
          ext_sel     = ext_r[0];
          slot_str[k] = stride_r[0];
        end
        2'd1: begin
          ext_sel     = ext_r[1];
          slot_str[k] = stride_r[1];
        end
        2'd2: begin
          ext_sel     = ext_r[2];
          slot_str[k] = stride_r[2];
        end
        default: begin
          ext_sel     = 16'd1;
          slot_str[k] = '0;
        end
      endcase
      if ((2'(k) < rank_eff) && (ext_sel != '0)) begin
        slot_ext[k] = ext_sel;
      end else begin
        slot_ext[k] = 16'd1;
      end
    end
  end

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign base_wide = {64'd0, base_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx0_r  <= in_linear_index;
      addr0_r <= base_wide[ADDR_WIDTH-1:0];
    end
  end

  assign slot_vld[0]  = vld0_r;
  assign slot_idx[0]  = idx0_r;
  assign slot_addr[0] = addr0_r;

  genvar k;
  generate
    for (k = 0; k < MAX_RANK; k++) begin : g_slot
      sta_slot #(.AW(ADDR_WIDTH)) u_slot (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (slot_vld[k]),
        .in_idx   (slot_idx[k]),
        .in_addr  (slot_addr[k]),
        .ext      (slot_ext[k]),
        .stride   (slot_str[k]),
        .out_vld  (slot_vld[k+1]),
        .out_idx  (slot_idx[k+1]),
        .out_addr (slot_addr[k+1])
      );
    end
  endgenerate

  assign out_valid           = slot_vld[MAX_RANK];
  assign out_element_address = slot_addr[MAX_RANK];

  a_rank_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    rank_eff <= 2'(MAX_RANK))
    else $error("effective rank exceeds MAX_RANK");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld0_r)
    else $error("accepted transaction did not enter the pipeline");

  a_bubble_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_valid && !in_stall) |=> !vld0_r)
    else $error("pipeline created a transaction from nothing");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_element_address)))
    else $error("stalled result was lost or changed");

endmodule
